FILE: design/qzce_pkg.sv
// Shared constants and helpers for the quad zero-crossing edgel detector.
// Depends on nothing; imported by quad_zero_crossing_edgels.
package qzce_pkg;

  // Line buffer and field sizes
  localparam int unsigned MaxWidth    = 2048;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned HeightLimit = 2048;
  localparam int unsigned ColBits     = $clog2(MaxWidth);
  localparam int unsigned RowBits     = $clog2(HeightLimit);
  localparam int unsigned CfgBits     = 12;
  localparam int unsigned CoordBits   = 12;
  localparam int unsigned MidBits     = 13;
  localparam int unsigned MagBits     = 16;
  localparam int unsigned OriBits     = 2;
  localparam int unsigned OutFieldBits =
      4 * CoordBits + 2 * MidBits + MagBits + OriBits;
  localparam int unsigned OutDataBits = ((OutFieldBits + 7) / 8) * 8;

  // Register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [CfgBits-1:0] WidthReset  = CfgBits'(640);
  localparam logic [CfgBits-1:0] HeightReset = CfgBits'(480);

  // Quad sides, in test order
  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_TOP    = 2'd1;
  localparam logic [1:0] SIDE_BOTTOM = 2'd2;
  localparam logic [1:0] SIDE_RIGHT  = 2'd3;

  // Magnitudes, Q1.15
  localparam logic [MagBits-1:0] MagAxis = MagBits'(32768);
  localparam logic [MagBits-1:0] MagDiag = MagBits'(23170);

  // Orientation codes, k * pi/4
  localparam logic [OriBits-1:0] ORI_0   = 2'd0;
  localparam logic [OriBits-1:0] ORI_45  = 2'd1;
  localparam logic [OriBits-1:0] ORI_90  = 2'd2;
  localparam logic [OriBits-1:0] ORI_135 = 2'd3;

  // Row-direction offset of a side's crossing point (half pixels)
  function automatic logic [1:0] side_off_a(input logic [1:0] side);
    logic [1:0] off;
    case (side)
      SIDE_LEFT:   off = 2'd1;
      SIDE_TOP:    off = 2'd0;
      SIDE_BOTTOM: off = 2'd2;
      default:     off = 2'd1;
    endcase
    return off;
  endfunction

  // Column-direction offset of a side's crossing point (half pixels)
  function automatic logic [1:0] side_off_b(input logic [1:0] side);
    logic [1:0] off;
    case (side)
      SIDE_LEFT:   off = 2'd0;
      SIDE_TOP:    off = 2'd1;
      SIDE_BOTTOM: off = 2'd1;
      default:     off = 2'd2;
    endcase
    return off;
  endfunction

  // Strict sign change between two samples; zero is neither sign
  function automatic logic sign_change(input logic [SampleBits-1:0] x,
                                       input logic [SampleBits-1:0] y);
    logic x_neg, x_pos, y_neg, y_pos;
    x_neg = x[SampleBits-1];
    x_pos = !x[SampleBits-1] && (|x);
    y_neg = y[SampleBits-1];
    y_pos = !y[SampleBits-1] && (|y);
    return (x_pos && y_neg) || (x_neg && y_pos);
  endfunction

endpackage

FILE: design/quad_zero_crossing_edgels.sv
// Latency: an edgel is held in stage 1 and then in the output register before it is
// offered on the master side. Throughput: one sample per cycle while the master side
// does not stall, set by the single read-modify-write of the line buffer memory per sample.
// Reset clears counters, neighbor samples, pipeline valids and registers
// (width 640, height 480). The line buffer is not cleared; there is no
// clearing pass, and entries not yet written read as undefined.
// Top level of the quad zero-crossing edgel detector.
// Depends on qzce_pkg for sizes, codes and the sign-change test.
module quad_zero_crossing_edgels
  import qzce_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration writes
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CfgBits-1:0]     cfg_data_i,
  // Sample stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SampleBits-1:0]  s_axis_tdata,   // [15:0] sample
  // Edgel stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // from bit 0: first_a[11:0], first_b, second_a, second_b (12 each),
  // mid_a[13], mid_b[13], magnitude[16], orientation[2], zero pad[4]
  output logic [OutDataBits-1:0] m_axis_tdata
);

  // Configuration registers and clamped views
  logic [CfgBits-1:0] width_cfg_q, height_cfg_q;
  logic [CfgBits-1:0] width_eff, height_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= WidthReset;
      height_cfg_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_cfg_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_cfg_q < CfgBits'(2))             width_eff = CfgBits'(2);
    else if (width_cfg_q > CfgBits'(MaxWidth)) width_eff = CfgBits'(MaxWidth);
    else                                       width_eff = width_cfg_q;
    if (height_cfg_q < CfgBits'(2))                 height_eff = CfgBits'(2);
    else if (height_cfg_q > CfgBits'(HeightLimit))  height_eff = CfgBits'(HeightLimit);
    else                                            height_eff = height_cfg_q;
  end

  // Pipeline handshake
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_xfer;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Raster counters
  logic [ColBits-1:0] col_q, col_d;
  logic [RowBits-1:0] row_q, row_d;
  logic [CfgBits-1:0] col_inc, row_inc;

  always_comb begin
    col_inc = CfgBits'(col_q) + CfgBits'(1);
    row_inc = CfgBits'(row_q) + CfgBits'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (col_inc >= width_eff) begin
      col_d = '0;
      row_d = (row_inc >= height_eff) ? '0 : row_inc[RowBits-1:0];
    end else begin
      col_d = col_inc[ColBits-1:0];
    end
    // Wrap at once if the height shrank below the current row
    if (CfgBits'(row_d) >= height_eff) row_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line buffer: read the previous row's sample and overwrite it in one access
  logic [SampleBits-1:0] row_mem [MaxWidth];
  logic [SampleBits-1:0] above_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      above_q        <= row_mem[col_q];
      row_mem[col_q] <= s_axis_tdata;
    end
  end

  // Stage 1: current sample, left neighbor and position of the quad
  logic [SampleBits-1:0] cur_q, left_cur_q, left_above_q;
  logic [ColBits-1:0]    s1_col_q;
  logic [RowBits-1:0]    s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      cur_q        <= '0;
      left_cur_q   <= '0;
      left_above_q <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        left_cur_q <= cur_q;
        cur_q      <= s_axis_tdata;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      // The above sample becomes the next quad's top-left once consumed
      if (s1_adv) left_above_q <= above_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // Quad evaluation
  logic [3:0]           hit;
  logic [2:0]           n_hit;
  logic                 emit;
  logic [1:0]           f_side, s_side;
  logic [CoordBits-1:0] i2, j2;
  logic [CoordBits-1:0] fa, fb, sa, sb;
  logic [MidBits-1:0]   ma, mb;
  logic [MagBits-1:0]   mag;
  logic [OriBits-1:0]   ori;

  always_comb begin
    hit[SIDE_LEFT]   = sign_change(left_above_q, left_cur_q);
    hit[SIDE_TOP]    = sign_change(left_above_q, above_q);
    hit[SIDE_BOTTOM] = sign_change(left_cur_q, cur_q);
    hit[SIDE_RIGHT]  = sign_change(above_q, cur_q);
    n_hit = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]);
    emit  = (s1_row_q != '0) && (s1_col_q != '0) && (n_hit == 3'd2);

    // First is the lowest set side, second the highest
    if (hit[SIDE_LEFT])        f_side = SIDE_LEFT;
    else if (hit[SIDE_TOP])    f_side = SIDE_TOP;
    else if (hit[SIDE_BOTTOM]) f_side = SIDE_BOTTOM;
    else                       f_side = SIDE_RIGHT;
    if (hit[SIDE_RIGHT])       s_side = SIDE_RIGHT;
    else if (hit[SIDE_BOTTOM]) s_side = SIDE_BOTTOM;
    else if (hit[SIDE_TOP])    s_side = SIDE_TOP;
    else                       s_side = SIDE_LEFT;

    i2 = {CoordBits'(s1_row_q) - CoordBits'(1)} << 1;
    j2 = {CoordBits'(s1_col_q) - CoordBits'(1)} << 1;
    fa = i2 + CoordBits'(side_off_a(f_side));
    fb = j2 + CoordBits'(side_off_b(f_side));
    sa = i2 + CoordBits'(side_off_a(s_side));
    sb = j2 + CoordBits'(side_off_b(s_side));
    ma = MidBits'(fa) + MidBits'(sa);
    mb = MidBits'(fb) + MidBits'(sb);

    // Axis pairs first, then the diagonal direction by row order
    if (f_side == SIDE_LEFT && s_side == SIDE_RIGHT) begin
      mag = MagAxis;
      ori = ORI_90;
    end else if (f_side == SIDE_TOP && s_side == SIDE_BOTTOM) begin
      mag = MagAxis;
      ori = ORI_0;
    end else if (sa > fa) begin
      mag = MagDiag;
      ori = ORI_45;
    end else begin
      mag = MagDiag;
      ori = ORI_135;
    end
  end

  // Output register
  logic [OutDataBits-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_data_q <= {(OutDataBits - OutFieldBits)'(0), ori, mag, mb, ma, sb, sa, fb, fa};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
